// File: rtl/byte_run_hex_escaper_assert.svh
// Assertion macros for the byte run hex escaper RTL.
// Needs nothing else; files that assert include this header by name.
`ifndef BYTE_RUN_HEX_ESCAPER_ASSERT_SVH
`define BYTE_RUN_HEX_ESCAPER_ASSERT_SVH

`ifndef ASSERT_OFF
`define BRHE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define BRHE_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define BRHE_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define BRHE_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

// File: rtl/brhe_pkg.sv
// Shared types and character constants for the byte run hex escaper.
// No dependencies.
`default_nettype none

package brhe_pkg;

   typedef enum logic [0:0] {
      KIND_TEXT = 1'b0,
      KIND_HEX  = 1'b1
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic         run_open;
      logic         final_byte;
      logic [7:0]   data_byte;
   } cmd_type;

   localparam logic [7:0] CHAR_LT    = 8'h3C;
   localparam logic [7:0] CHAR_GT    = 8'h3E;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

endpackage

`default_nettype wire

// File: rtl/byte_run_hex_escaper.sv
// Byte run hex escaper, top level.
// Input side is a queue: write a beat with req_push while req_full is low.
// Each beat carries req_data_byte and req_final_byte (last byte of a message).
// Output side is a queue: while rsp_empty is low, rsp_out_char holds the
// oldest character; rsp_pop takes it. rsp_item_done marks the last character
// of an input byte, rsp_message_done the last character of a message.
// Printable bytes pass through; runs of other bytes become <XX XX ...>.
// A beat is first written into the command queue; the back end then loads
// its first character into the output register, which drives rsp_out_char.
// Throughput: one character per cycle from the output register while the receiver pops;
// a byte expands to 1 to 4 characters, 3 inside a hex run. The front end
// keeps taking bytes into a CMD_DEPTH entry command queue while the back end
// expands earlier ones.
// If the receiver stalls, the output holds and the command queue fills; then
// req_full rises until rsp_pop drains it.
// Reset clears the queue, the output register and the open-run flag.
`default_nettype none

module byte_run_hex_escaper import brhe_pkg::*; #(
   parameter int CMD_DEPTH = 4
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   output logic            req_full,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_final_byte,
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output logic [7:0]      rsp_out_char,
   output logic            rsp_item_done,
   output logic            rsp_message_done
);

   logic    cmd_push;
   cmd_type cmd_wr;
   logic    cmd_full;
   logic    cmd_pop;
   logic    cmd_valid;
   cmd_type cmd_head;

   assign req_full = cmd_full;

   brhe_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .cmd_full       (cmd_full),
      .cmd_push       (cmd_push),
      .cmd_data       (cmd_wr)
   );

   brhe_cmd_fifo #(
      .DEPTH (CMD_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_data  (cmd_wr),
      .full       (cmd_full),
      .pop        (cmd_pop),
      .head_valid (cmd_valid),
      .head_data  (cmd_head)
   );

   brhe_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (cmd_valid),
      .cmd_data         (cmd_head),
      .cmd_pop          (cmd_pop),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_out_char     (rsp_out_char),
      .rsp_item_done    (rsp_item_done),
      .rsp_message_done (rsp_message_done)
   );

endmodule

`default_nettype wire

// File: rtl/brhe_front.sv
// Front end: accepts input beats, classifies each byte and tracks the open hex run.
// Depends on brhe_pkg.
`default_nettype none

module brhe_front import brhe_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_final_byte,
   input  wire logic       cmd_full,
   output logic            cmd_push,
   output cmd_type         cmd_data
);

   logic hex_run_open_ff;
   logic hex_run_open_in;
   logic printable;

   always_comb begin
      printable = ((req_data_byte >= 8'h20) && (req_data_byte <= 8'h7E)) ||
                  ((req_data_byte >= 8'h09) && (req_data_byte <= 8'h0D));
   end

   assign cmd_push = req_push && !cmd_full;

   always_comb begin
      cmd_data.kind       = printable ? KIND_TEXT : KIND_HEX;
      cmd_data.run_open   = hex_run_open_ff;
      cmd_data.final_byte = req_final_byte;
      cmd_data.data_byte  = req_data_byte;
   end

   always_comb begin
      hex_run_open_in = hex_run_open_ff;
      if (cmd_push) begin
         hex_run_open_in = !printable && !req_final_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hex_run_open_ff <= 1'b0;
      end else begin
         hex_run_open_ff <= hex_run_open_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/brhe_cmd_fifo.sv
// Short register queue of classified commands between front and back end.
// Depends on brhe_pkg.
`default_nettype none

module brhe_cmd_fifo import brhe_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  cmd_type   push_data,
   output logic      full,
   input  wire logic pop,
   output logic      head_valid,
   output cmd_type   head_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: rtl/brhe_back.sv
// Back end: expands each command into output characters, one per cycle while rsp_pop keeps up.
// Depends on brhe_pkg and byte_run_hex_escaper_assert.svh.
`default_nettype none
`include "byte_run_hex_escaper_assert.svh"

module brhe_back import brhe_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  cmd_valid,
   input  cmd_type    cmd_data,
   output logic       cmd_pop,
   input  wire logic  rsp_pop,
   output logic       rsp_empty,
   output logic [7:0] rsp_out_char,
   output logic       rsp_item_done,
   output logic       rsp_message_done
);

   logic       out_valid_ff, out_valid_in;
   logic [7:0] char_ff, char_in;
   logic       item_done_ff, msg_done_ff;
   logic [1:0] step_ff, step_in;
   logic [1:0] last_step;
   logic       is_last;
   logic       load;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      hex_char = (nib < 4'd10) ? (8'h30 + {4'h0, nib}) : (8'h37 + {4'h0, nib});
   endfunction

   always_comb begin
      case (cmd_data.kind)
         KIND_TEXT: last_step = cmd_data.run_open ? 2'd1 : 2'd0;
         KIND_HEX:  last_step = cmd_data.final_byte ? 2'd3 : 2'd2;
         default:   last_step = 2'd0;
      endcase
   end

   always_comb begin
      char_in = cmd_data.data_byte;
      case (cmd_data.kind)
         KIND_TEXT: begin
            if (cmd_data.run_open && (step_ff == 2'd0)) begin
               char_in = CHAR_GT;
            end
         end
         KIND_HEX: begin
            case (step_ff)
               2'd0:    char_in = cmd_data.run_open ? CHAR_SPACE : CHAR_LT;
               2'd1:    char_in = hex_char(cmd_data.data_byte[7:4]);
               2'd2:    char_in = hex_char(cmd_data.data_byte[3:0]);
               default: char_in = CHAR_GT;
            endcase
         end
         default: char_in = cmd_data.data_byte;
      endcase
   end

   assign is_last = (step_ff == last_step);
   assign load    = cmd_valid && (!out_valid_ff || rsp_pop);
   assign cmd_pop = load && is_last;

   always_comb begin
      step_in      = step_ff;
      out_valid_in = out_valid_ff;
      if (load) begin
         step_in      = is_last ? 2'd0 : step_ff + 2'd1;
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         step_ff      <= 2'd0;
      end else begin
         out_valid_ff <= out_valid_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         char_ff      <= char_in;
         item_done_ff <= is_last;
         msg_done_ff  <= is_last && cmd_data.final_byte;
      end
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_out_char     = char_ff;
   assign rsp_item_done    = item_done_ff;
   assign rsp_message_done = msg_done_ff;

   `BRHE_ASSERT_IMP(a_pop_has_cmd, clock, reset, cmd_pop, cmd_valid)
   `BRHE_ASSERT_IMP(a_mid_cmd_held, clock, reset, step_ff != 2'd0, cmd_valid)
   `BRHE_ASSERT_IMP(a_msg_ends_item, clock, reset, out_valid_ff && msg_done_ff, item_done_ff)
   `BRHE_ASSERT_NXT(a_load_valid, clock, reset, load, out_valid_ff)

endmodule

`default_nettype wire
